// ===== hdl/voxel_face_mesher_with_ao_defines.svh =====
// Assertion macros for the checker of the voxel face mesher.
`ifndef VOXEL_FACE_MESHER_WITH_AO_DEFINES_SVH
`define VOXEL_FACE_MESHER_WITH_AO_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define VFM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("voxel face mesher: assertion failed");

// Assertion that is also checked while reset is held.
`define VFM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("voxel face mesher: reset assertion failed");

`endif

// ===== hdl/vfm_pkg.sv =====
package vfm_pkg;

  localparam int COORD_W = 6;
  localparam int NB_W    = 27;
  localparam int TEX_W   = 9;
  localparam int DIR_N   = 6;
  localparam int DIR_W   = 3;
  localparam int VTX_N   = 4;
  localparam int VTX_W   = 2;
  localparam int AO_W    = 2;
  localparam int WORD_W  = 32;
  localparam int NBI_W   = 5;

  localparam logic [COORD_W-1:0] COORD_MAX = 6'd63;
  localparam logic [VTX_W-1:0]   VTX_LAST  = 2'd3;
  localparam logic [AO_W-1:0]    AO_FULL   = 2'd3;
  localparam logic [AO_W-1:0]    AO_DARK   = 2'd0;

  // Neighbourhood bit of the face neighbour, per direction +X,+Y,+Z,-X,-Y,-Z.
  localparam logic [NBI_W-1:0] FACE_BIT [DIR_N] = '{
    5'd14, 5'd16, 5'd22, 5'd12, 5'd10, 5'd4
  };

  // Corner offset of each vertex as {dx, dy, dz}.
  localparam logic [2:0] CORNER_OFF [DIR_N][VTX_N] = '{
    '{3'b100, 3'b110, 3'b111, 3'b101},
    '{3'b111, 3'b110, 3'b010, 3'b011},
    '{3'b001, 3'b101, 3'b111, 3'b011},
    '{3'b001, 3'b011, 3'b010, 3'b000},
    '{3'b001, 3'b000, 3'b100, 3'b101},
    '{3'b010, 3'b110, 3'b100, 3'b000}
  };

  // Neighbourhood bits of the occlusion samples: side one, side two, corner.
  localparam logic [NBI_W-1:0] OCC_BIT [DIR_N][VTX_N][3] = '{
    '{'{5'd5,  5'd11, 5'd2 }, '{5'd17, 5'd5,  5'd8 },
      '{5'd23, 5'd17, 5'd26}, '{5'd11, 5'd23, 5'd20}},
    '{'{5'd17, 5'd25, 5'd26}, '{5'd7,  5'd17, 5'd8 },
      '{5'd15, 5'd7,  5'd6 }, '{5'd25, 5'd15, 5'd24}},
    '{'{5'd19, 5'd21, 5'd18}, '{5'd23, 5'd19, 5'd20},
      '{5'd25, 5'd23, 5'd26}, '{5'd21, 5'd25, 5'd24}},
    '{'{5'd21, 5'd9,  5'd18}, '{5'd15, 5'd21, 5'd24},
      '{5'd3,  5'd15, 5'd6 }, '{5'd9,  5'd3,  5'd0 }},
    '{'{5'd9,  5'd19, 5'd18}, '{5'd1,  5'd9,  5'd0 },
      '{5'd11, 5'd1,  5'd2 }, '{5'd19, 5'd11, 5'd20}},
    '{'{5'd7,  5'd3,  5'd6 }, '{5'd5,  5'd7,  5'd8 },
      '{5'd1,  5'd5,  5'd2 }, '{5'd3,  5'd1,  5'd0 }}
  };

  // One voxel as it arrives.
  typedef struct packed {
    logic [COORD_W-1:0]            pos_x;
    logic [COORD_W-1:0]            pos_y;
    logic [COORD_W-1:0]            pos_z;
    logic                          solid;
    logic [NB_W-1:0]               nb;
    logic [DIR_N-1:0][TEX_W-1:0]   tex;
  } vfm_voxel_t;

  // One voxel after face culling and occlusion.
  typedef struct packed {
    logic [COORD_W-1:0]                      pos_x;
    logic [COORD_W-1:0]                      pos_y;
    logic [COORD_W-1:0]                      pos_z;
    logic [DIR_N-1:0]                        face;
    logic [DIR_N-1:0][VTX_N-1:0][AO_W-1:0]   ao;
    logic [DIR_N-1:0][TEX_W-1:0]             tex;
  } vfm_quad_t;

endpackage

// ===== hdl/vfm_if.sv =====
// Voxel input channel.
interface vfm_in_if;
  logic                        valid;
  logic                        ready;
  logic [vfm_pkg::COORD_W-1:0] pos_x;
  logic [vfm_pkg::COORD_W-1:0] pos_y;
  logic [vfm_pkg::COORD_W-1:0] pos_z;
  logic                        solid;
  logic [vfm_pkg::NB_W-1:0]    neighbour_opaque;
  logic [vfm_pkg::TEX_W-1:0]   tex_pos_x;
  logic [vfm_pkg::TEX_W-1:0]   tex_pos_y;
  logic [vfm_pkg::TEX_W-1:0]   tex_pos_z;
  logic [vfm_pkg::TEX_W-1:0]   tex_neg_x;
  logic [vfm_pkg::TEX_W-1:0]   tex_neg_y;
  logic [vfm_pkg::TEX_W-1:0]   tex_neg_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, solid, neighbour_opaque,
           tex_pos_x, tex_pos_y, tex_pos_z, tex_neg_x, tex_neg_y, tex_neg_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, solid, neighbour_opaque,
           tex_pos_x, tex_pos_y, tex_pos_z, tex_neg_x, tex_neg_y, tex_neg_z,
    output ready
  );
endinterface

// Vertex output channel.
interface vfm_out_if;
  logic                       valid;
  logic                       ready;
  logic [vfm_pkg::WORD_W-1:0] vertex_word;
  logic                       last;

  modport source (output valid, vertex_word, last, input ready);
  modport sink (input valid, vertex_word, last, output ready);
endinterface

// ===== hdl/voxel_face_mesher_with_ao.sv =====
// Voxel face mesher with per-vertex ambient occlusion.
// in_ch carries one voxel per transaction: position, solid flag, the opacity
// of its 3x3x3 neighbourhood and six face texture ids. out_ch carries packed
// vertex words, four per visible face in the order +X,+Y,+Z,-X,-Y,-Z, with
// last set on the final word of each voxel. Air voxels, voxels with a
// coordinate of 63 and fully enclosed voxels give no transaction at all.
// Pipeline: input register, cull and occlusion stage, a quad serialiser and
// an output register, which a voxel passes in that order before its first
// word is offered on out_ch.
// Throughput: the serialiser sends one vertex word per cycle unless out_ch
// stalls, and keeps a voxel until all its faces are sent; voxels that emit
// nothing pass at one per cycle unless held. Input is taken while the serialiser
// is still working on earlier voxels, as long as the stages in front hold space.
// Reset (rst_n low at a clock edge) empties every stage; in_ch.ready is high
// and out_ch.valid low after it. When the receiver stalls, the output word is
// held and the stages behind it fill, then in_ch.ready falls; nothing is lost.
module voxel_face_mesher_with_ao (
  input  logic         clk,
  input  logic         rst_n,
  vfm_in_if.sink       in_ch,
  vfm_out_if.source    out_ch
);

  logic                  s1_v_r, s1_v_nxt;
  vfm_pkg::vfm_voxel_t   s1_r;
  logic                  s2_v_r, s2_v_nxt;
  vfm_pkg::vfm_quad_t    s2_r, s2_nxt;
  logic                  ser_v_r, ser_v_nxt;
  logic [vfm_pkg::DIR_N-1:0] ser_face_r, ser_face_nxt;
  logic [vfm_pkg::VTX_W-1:0] ser_vtx_r, ser_vtx_nxt;
  vfm_pkg::vfm_quad_t    ser_r;
  logic                  out_v_r, out_v_nxt;
  logic [vfm_pkg::WORD_W-1:0] out_word_r;
  logic                  out_last_r;

  logic out_load, ser_done, ser_free, ser_take, s2_leave, s2_free, s2_take, s1_take;
  logic emit;
  logic [vfm_pkg::DIR_N-1:0] dir_hot, face_rest;
  logic [vfm_pkg::DIR_W-1:0] cur_dir;
  logic [2:0] corner;
  logic [vfm_pkg::COORD_W-1:0] vx, vy, vz;
  logic [vfm_pkg::WORD_W-1:0] word_nxt;
  logic last_nxt;

  // Handshake chain from the output register back to the input.
  assign out_load  = !out_v_r || out_ch.ready;
  assign ser_done  = ser_v_r && out_load && (ser_vtx_r == vfm_pkg::VTX_LAST) &&
                     (face_rest == '0);
  assign ser_free  = !ser_v_r || ser_done;
  assign ser_take  = s2_v_r && (s2_r.face != '0) && ser_free;
  assign s2_leave  = s2_v_r && ((s2_r.face == '0) || ser_free);
  assign s2_free   = !s2_v_r || s2_leave;
  assign s2_take   = s1_v_r && s2_free;
  assign s1_take   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !s1_v_r || s2_free;

  // Face culling and occlusion of the voxel in the input register.
  always_comb begin
    logic sa, sb, sc;
    emit = s1_r.solid && (s1_r.pos_x != vfm_pkg::COORD_MAX) &&
           (s1_r.pos_y != vfm_pkg::COORD_MAX) && (s1_r.pos_z != vfm_pkg::COORD_MAX);
    s2_nxt.pos_x = s1_r.pos_x;
    s2_nxt.pos_y = s1_r.pos_y;
    s2_nxt.pos_z = s1_r.pos_z;
    s2_nxt.tex   = s1_r.tex;
    for (int d = 0; d < vfm_pkg::DIR_N; d++) begin
      s2_nxt.face[d] = emit && !s1_r.nb[vfm_pkg::FACE_BIT[d]];
      for (int v = 0; v < vfm_pkg::VTX_N; v++) begin
        sa = s1_r.nb[vfm_pkg::OCC_BIT[d][v][0]];
        sb = s1_r.nb[vfm_pkg::OCC_BIT[d][v][1]];
        sc = s1_r.nb[vfm_pkg::OCC_BIT[d][v][2]];
        if (sa && sb) begin
          s2_nxt.ao[d][v] = vfm_pkg::AO_DARK;
        end else begin
          s2_nxt.ao[d][v] = vfm_pkg::AO_FULL - {1'b0, sa} - {1'b0, sb} - {1'b0, sc};
        end
      end
    end
  end

  // Current direction is the lowest face still to send.
  always_comb begin
    dir_hot   = ser_face_r & (~ser_face_r + 1'b1);
    face_rest = ser_face_r & ~dir_hot;
    cur_dir   = '0;
    for (int d = vfm_pkg::DIR_N - 1; d >= 0; d--) begin
      if (ser_face_r[d]) begin
        cur_dir = vfm_pkg::DIR_W'(d);
      end
    end
  end

  // Vertex word assembly.
  always_comb begin
    corner   = vfm_pkg::CORNER_OFF[cur_dir][ser_vtx_r];
    vx       = ser_r.pos_x + {{(vfm_pkg::COORD_W-1){1'b0}}, corner[2]};
    vy       = ser_r.pos_y + {{(vfm_pkg::COORD_W-1){1'b0}}, corner[1]};
    vz       = ser_r.pos_z + {{(vfm_pkg::COORD_W-1){1'b0}}, corner[0]};
    word_nxt = {vx, vy, vz, cur_dir, ser_r.ao[cur_dir][ser_vtx_r], ser_r.tex[cur_dir]};
    last_nxt = (ser_vtx_r == vfm_pkg::VTX_LAST) && (face_rest == '0);
  end

  // Next valid bits and serialiser counters.
  always_comb begin
    s1_v_nxt     = s1_v_r;
    s2_v_nxt     = s2_v_r;
    ser_v_nxt    = ser_v_r;
    ser_face_nxt = ser_face_r;
    ser_vtx_nxt  = ser_vtx_r;
    out_v_nxt    = out_v_r;
    if (s1_take) begin
      s1_v_nxt = 1'b1;
    end else if (s2_take) begin
      s1_v_nxt = 1'b0;
    end
    if (s2_take) begin
      s2_v_nxt = 1'b1;
    end else if (s2_leave) begin
      s2_v_nxt = 1'b0;
    end
    if (ser_v_r && out_load) begin
      ser_vtx_nxt = ser_vtx_r + 1'b1;
      if (ser_vtx_r == vfm_pkg::VTX_LAST) begin
        ser_face_nxt = face_rest;
      end
      if (ser_done) begin
        ser_v_nxt = 1'b0;
      end
    end
    if (ser_take) begin
      ser_v_nxt    = 1'b1;
      ser_face_nxt = s2_r.face;
      ser_vtx_nxt  = '0;
    end
    if (out_load) begin
      out_v_nxt = ser_v_r;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      ser_v_r    <= 1'b0;
      ser_face_r <= '0;
      ser_vtx_r  <= '0;
      out_v_r    <= 1'b0;
    end else begin
      s1_v_r     <= s1_v_nxt;
      s2_v_r     <= s2_v_nxt;
      ser_v_r    <= ser_v_nxt;
      ser_face_r <= ser_face_nxt;
      ser_vtx_r  <= ser_vtx_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_r.pos_x <= in_ch.pos_x;
      s1_r.pos_y <= in_ch.pos_y;
      s1_r.pos_z <= in_ch.pos_z;
      s1_r.solid <= in_ch.solid;
      s1_r.nb    <= in_ch.neighbour_opaque;
      s1_r.tex   <= {in_ch.tex_neg_z, in_ch.tex_neg_y, in_ch.tex_neg_x,
                     in_ch.tex_pos_z, in_ch.tex_pos_y, in_ch.tex_pos_x};
    end
    if (s2_take) begin
      s2_r <= s2_nxt;
    end
    if (ser_take) begin
      ser_r <= s2_r;
    end
    if (out_load) begin
      out_word_r <= word_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.vertex_word = out_word_r;
  assign out_ch.last        = out_last_r;

endmodule

// ===== hdl/vfm_checker.sv =====
`include "voxel_face_mesher_with_ao_defines.svh"

module vfm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [vfm_pkg::WORD_W-1:0] out_word,
  input logic                       out_last
);

  // A stalled word stays offered.
  `VFM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid)

  // A stalled word and its last flag do not change.
  `VFM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_word) && $stable(out_last))

  // Reset empties the pipeline: input open, nothing offered.
  `VFM_ASSERT_RST(a_reset_empty, !rst_n |=> in_ready && !out_valid)

  // The direction field only ever holds one of the six directions.
  `VFM_ASSERT(a_dir_range, out_valid |-> (out_word[13:11] != 3'd6) && (out_word[13:11] != 3'd7))

endmodule

bind voxel_face_mesher_with_ao vfm_checker u_vfm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_word  (out_ch.vertex_word),
  .out_last  (out_ch.last)
);
